>>> rtl/sukt_pkg.sv
`timescale 1ns / 1ps

package sukt_pkg;

	// table size and derived widths
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// request and result field widths
	localparam int KEY_W    = 32;
	localparam int CMD_W    = 2;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 3;
	localparam int WHERE_W  = 5;
	localparam int COUNT_W  = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LK_RD,
		S_LK_CMP,
		S_SH_CHK,
		S_SH_WR,
		S_DEL_CHK,
		S_DEL_WR,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_INC,
		IDX_DEC,
		IDX_POS,
		IDX_COUNT
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_DN,
		RD_UP
	} rd_sel_t;

	typedef enum logic {
		WR_KEY,
		WR_DATA
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		WH_ZERO,
		WH_IDX,
		WH_MARK,
		WH_POS
	} where_sel_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                load;
		idx_op_t             idx_op;
		logic                mark_set;
		logic                rd_en;
		rd_sel_t             rd_sel;
		logic                wr_en;
		wr_sel_t             wr_sel;
		cnt_op_t             cnt_op;
		logic                res_set;
		logic [STATUS_W-1:0] res_status;
		where_sel_t          res_where;
		logic                out_load;
	} dp_ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             pos_bad;
		logic             idx_at_count;
		logic             idx_at_mark;
		logic             del_last;
		logic             key_eq;
		logic             key_gt;
		logic             out_free;
	} dp_stat_t;

endpackage

>>> rtl/sukt_dp.sv
`timescale 1ns / 1ps

module sukt_dp
	import sukt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_ctl_t             ctl,
	output dp_stat_t            stat,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    key_value,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [WHERE_W-1:0]  where,
	output logic [COUNT_W-1:0]  entry_count
);

	logic [KEY_W-1:0]    key_store [TABLE_DEPTH];
	logic [KEY_W-1:0]    key_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    mark_q;
	logic [CNT_W-1:0]    count_q;
	logic [KEY_W-1:0]    rd_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [WHERE_W-1:0]  res_where_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [WHERE_W-1:0]  out_where_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [CNT_W-1:0]    idx_up;
	logic [CNT_W-1:0]    idx_dn;
	logic [IDX_W-1:0]    rd_addr;
	logic [KEY_W-1:0]    wr_data;
	logic [WHERE_W-1:0]  where_d;

	assign idx_up = idx_q + CNT_W'(1);
	assign idx_dn = idx_q - CNT_W'(1);

	// request capture, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= key_value;
			cmd_q <= cmd;
			pos_q <= position;
		end
	end

	// walking index and insert mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			mark_q <= '0;
		end else begin
			if (ctl.load) begin
				idx_q <= '0;
			end else begin
				case (ctl.idx_op)
					IDX_INC:   idx_q <= idx_up;
					IDX_DEC:   idx_q <= idx_dn;
					IDX_POS:   idx_q <= CNT_W'(pos_q);
					IDX_COUNT: idx_q <= count_q;
					default:   idx_q <= idx_q;
				endcase
			end
			if (ctl.mark_set) begin
				mark_q <= idx_q;
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctl.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// key memory, one write and one registered read per cycle
	always_comb begin
		case (ctl.rd_sel)
			RD_DN:   rd_addr = idx_dn[IDX_W-1:0];
			RD_UP:   rd_addr = idx_up[IDX_W-1:0];
			default: rd_addr = idx_q[IDX_W-1:0];
		endcase
	end

	assign wr_data = (ctl.wr_sel == WR_KEY) ? key_q : rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_store[idx_q[IDX_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= key_store[rd_addr];
		end
	end

	// result staging
	always_comb begin
		case (ctl.res_where)
			WH_IDX:  where_d = idx_q[WHERE_W-1:0];
			WH_MARK: where_d = mark_q[WHERE_W-1:0];
			WH_POS:  where_d = WHERE_W'(pos_q);
			default: where_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.res_set) begin
			res_status_q <= ctl.res_status;
			res_where_q  <= where_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_where_q  <= res_where_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign where       = out_where_q;
	assign entry_count = out_count_q;

	// status toward the controller
	always_comb begin
		stat.cmd          = cmd_q;
		stat.full         = (count_q == CNT_W'(TABLE_DEPTH));
		stat.pos_bad      = (CNT_W'(pos_q) >= count_q);
		stat.idx_at_count = (idx_q == count_q);
		stat.idx_at_mark  = (idx_q == mark_q);
		stat.del_last     = (idx_up == count_q);
		stat.key_eq       = (rd_q == key_q);
		stat.key_gt       = (rd_q > key_q);
		stat.out_free     = !out_valid_q || !out_stall;
	end

endmodule

>>> rtl/sukt_ctrl.sv
`timescale 1ns / 1ps

module sukt_ctrl
	import sukt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.cmd == CMD_INSERT) begin
					state_d = stat.full ? S_FIN : S_LK_RD;
				end else if (stat.cmd == CMD_DELETE) begin
					state_d = stat.pos_bad ? S_FIN : S_DEL_CHK;
				end else if (stat.cmd == CMD_FIND) begin
					state_d = S_LK_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LK_RD: begin
				if (!stat.idx_at_count) begin
					state_d = S_LK_CMP;
				end else if (stat.cmd == CMD_INSERT) begin
					state_d = S_SH_CHK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LK_CMP: begin
				if (stat.key_eq) begin
					state_d = S_FIN;
				end else if (stat.key_gt) begin
					state_d = (stat.cmd == CMD_INSERT) ? S_SH_CHK : S_FIN;
				end else begin
					state_d = S_LK_RD;
				end
			end
			S_SH_CHK: begin
				state_d = stat.idx_at_mark ? S_FIN : S_SH_WR;
			end
			S_SH_WR: begin
				state_d = S_SH_CHK;
			end
			S_DEL_CHK: begin
				state_d = stat.del_last ? S_FIN : S_DEL_WR;
			end
			S_DEL_WR: begin
				state_d = S_DEL_CHK;
			end
			S_FIN: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl            = '0;
		ctl.idx_op     = IDX_HOLD;
		ctl.rd_sel     = RD_IDX;
		ctl.wr_sel     = WR_KEY;
		ctl.cnt_op     = CNT_HOLD;
		ctl.res_status = ST_DONE;
		ctl.res_where  = WH_ZERO;
		in_stall       = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			S_DECODE: begin
				if (stat.cmd == CMD_INSERT) begin
					if (stat.full) begin
						ctl.res_set    = 1'b1;
						ctl.res_status = ST_FULL;
					end
				end else if (stat.cmd == CMD_DELETE) begin
					if (stat.pos_bad) begin
						ctl.res_set    = 1'b1;
						ctl.res_status = ST_BADPOS;
					end else begin
						ctl.idx_op = IDX_POS;
					end
				end else if (stat.cmd != CMD_FIND) begin
					// unused code: done, nothing changes
					ctl.res_set = 1'b1;
				end
			end
			S_LK_RD: begin
				if (!stat.idx_at_count) begin
					ctl.rd_en = 1'b1;
				end else if (stat.cmd == CMD_INSERT) begin
					// new key goes past the last entry
					ctl.mark_set = 1'b1;
				end else begin
					ctl.res_set    = 1'b1;
					ctl.res_status = ST_NOTFOUND;
				end
			end
			S_LK_CMP: begin
				if (stat.key_eq) begin
					ctl.res_set = 1'b1;
					if (stat.cmd == CMD_INSERT) begin
						ctl.res_status = ST_DUP;
					end else begin
						ctl.res_where = WH_IDX;
					end
				end else if (stat.key_gt) begin
					if (stat.cmd == CMD_INSERT) begin
						ctl.mark_set = 1'b1;
						ctl.idx_op   = IDX_COUNT;
					end else begin
						ctl.res_set    = 1'b1;
						ctl.res_status = ST_NOTFOUND;
					end
				end else begin
					ctl.idx_op = IDX_INC;
				end
			end
			S_SH_CHK: begin
				if (stat.idx_at_mark) begin
					// drop the key into the gap
					ctl.wr_en     = 1'b1;
					ctl.wr_sel    = WR_KEY;
					ctl.cnt_op    = CNT_INC;
					ctl.res_set   = 1'b1;
					ctl.res_where = WH_MARK;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_DN;
				end
			end
			S_SH_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WR_DATA;
				ctl.idx_op = IDX_DEC;
			end
			S_DEL_CHK: begin
				if (stat.del_last) begin
					ctl.cnt_op    = CNT_DEC;
					ctl.res_set   = 1'b1;
					ctl.res_where = WH_POS;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_UP;
				end
			end
			S_DEL_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WR_DATA;
				ctl.idx_op = IDX_INC;
			end
			S_FIN: begin
				ctl.out_load = stat.out_free;
			end
			default: begin
				ctl.load = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/sorted_unique_key_table_top.sv
`timescale 1ns / 1ps
// channel   valid      stall      fields
// request   in_valid   in_stall   cmd, key_value, position
// result    out_valid  out_stall  status, where, entry_count
//
// one request at a time; a request waits in in_stall while the previous one runs.
// a refused or unused command goes from decode straight to the finish step; find and
// insert scan the keys with read and compare steps, and insert then shifts larger keys
// up toward the gap; delete moves the later keys down. each entry takes a read step,
// then a compare or write step, as the key memory read is registered.
// reset clears the count, index, mark and output valid flag; key memory is not cleared.
// a stalled result stays in the output register; the next request may start
// meanwhile and waits at its last step until the register frees.

module sorted_unique_key_table_top
	import sukt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_W-1:0]    key_value,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [WHERE_W-1:0]  where,
	output logic [COUNT_W-1:0]  entry_count
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer
	sukt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// key memory, counters and output register
	sukt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (cmd),
		.key_value   (key_value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.where       (where),
		.entry_count (entry_count)
	);

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sukt_pkg::*;

	// unused command code, answered as done with the table untouched
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_REQS  = 1650;
	localparam int POOL_SIZE    = 48;
	localparam int SETTLE_LIMIT = 4 * TABLE_DEPTH + 80;

	// stimulus phases: grow the table, mix all commands, shrink the table
	localparam int PHASE_FILL  = 0;
	localparam int PHASE_CHURN = 1;
	localparam int PHASE_DRAIN = 2;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] pos;
		int               gap_after;
		bit               wait_drained;
	} table_cmd_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WHERE_W-1:0]  where;
		logic [COUNT_W-1:0]  count;
	} table_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd = CMD_FIND;
	logic [KEY_W-1:0]    key_value = '0;
	logic [POS_W-1:0]    position = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WHERE_W-1:0]  where;
	logic [COUNT_W-1:0]  entry_count;

	// shadow copy of the sorted table
	logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	int               shadow_count = 0;
	int               peak_count = 0;

	table_cmd_t   cmd_queue [$];
	table_reply_t replies_due [$];
	table_cmd_t   next_cmd;
	table_reply_t due_reply;
	table_reply_t new_reply;

	logic         req_taken = 1'b0;
	int           gap_left = 0;
	int           stall_hold = 0;
	int           total_reqs = 0;
	int           accepted_reqs = 0;
	int           results_seen = 0;
	int           fail_count = 0;
	int           cmd_seen [4] = '{0, 0, 0, 0};
	int           full_seen = 0;
	int           dup_seen = 0;
	int           badpos_seen = 0;
	int           notfound_seen = 0;

	sorted_unique_key_table_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key_value  (key_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.where      (where),
		.entry_count(entry_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predict one command against the shadow table and update it
	function automatic table_reply_t apply_table_cmd(input logic [CMD_W-1:0] c,
		input logic [KEY_W-1:0] k, input logic [POS_W-1:0] p);
		table_reply_t r;
		int hit;
		int slot;
		r.status = ST_DONE;
		r.where = '0;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_keys[i] == k)
				hit = i;
		case (c)
			CMD_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else if (hit >= 0) begin
					r.status = ST_DUP;
				end else begin
					slot = shadow_count;
					while (slot > 0 && shadow_keys[slot-1] > k) begin
						shadow_keys[slot] = shadow_keys[slot-1];
						slot--;
					end
					shadow_keys[slot] = k;
					shadow_count++;
					r.where = WHERE_W'(slot);
				end
			end
			CMD_DELETE: begin
				if (int'(p) >= shadow_count) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = int'(p); i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_count--;
					r.where = p;
				end
			end
			CMD_FIND: begin
				if (hit < 0)
					r.status = ST_NOTFOUND;
				else
					r.where = WHERE_W'(hit);
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_count);
		return r;
	endfunction

	// idle cycles after a request: mostly none, some short, a few long
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 50);
	endfunction

	task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
		input logic [POS_W-1:0] p, input int gap, input bit drained);
		table_cmd_t t;
		t.cmd = c;
		t.key = k;
		t.pos = p;
		t.gap_after = gap;
		t.wait_drained = drained;
		cmd_queue.push_back(t);
		total_reqs++;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t ns mismatch on %s: got %0d, expected %0d",
			$time, what, got, want);
	endtask

	// request driver: holds a request until taken, then idles or sends the next
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !req_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_queue.size() > 0 &&
				!(cmd_queue[0].wait_drained && replies_due.size() > 0)) begin
				next_cmd = cmd_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= next_cmd.cmd;
				key_value <= next_cmd.key;
				position <= next_cmd.pos;
				gap_left <= next_cmd.gap_after;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall: alternating stall and free runs, some free runs long
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			case ($urandom_range(0, 9))
				0:       stall_hold <= $urandom_range(100, 300);
				1, 2, 3: stall_hold <= $urandom_range(5, 20);
				default: stall_hold <= $urandom_range(0, 4);
			endcase
		end else begin
			out_stall <= 1'b1;
			case ($urandom_range(0, 19))
				0:          stall_hold <= $urandom_range(20, 60);
				1, 2, 3:    stall_hold <= $urandom_range(3, 8);
				default:    stall_hold <= $urandom_range(0, 2);
			endcase
		end
	end

	// result checker and request predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			// results come from older requests, so check them first
			if (out_valid && !out_stall) begin
				results_seen++;
				if (replies_due.size() == 0) begin
					report_mismatch("result with nothing pending, status", int'(status), -1);
				end else begin
					due_reply = replies_due.pop_front();
					if (status !== due_reply.status)
						report_mismatch("status", int'(status), int'(due_reply.status));
					if (where !== due_reply.where)
						report_mismatch("where", int'(where), int'(due_reply.where));
					if (entry_count !== due_reply.count)
						report_mismatch("entry_count", int'(entry_count),
							int'(due_reply.count));
				end
			end
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				new_reply = apply_table_cmd(cmd, key_value, position);
				replies_due.push_back(new_reply);
				accepted_reqs++;
				cmd_seen[cmd]++;
				if (shadow_count > peak_count)
					peak_count = shadow_count;
				case (new_reply.status)
					ST_FULL:     full_seen++;
					ST_DUP:      dup_seen++;
					ST_BADPOS:   badpos_seen++;
					ST_NOTFOUND: notfound_seen++;
					default:     ;
				endcase
			end
		end
	end

	// stimulus, end of run and verdict
	initial begin : main_seq
		logic [KEY_W-1:0] key_pool [POOL_SIZE];
		logic [KEY_W-1:0] k;
		logic [CMD_W-1:0] c;
		logic [POS_W-1:0] p;
		int               phase;
		int               run_len;
		int               random_reqs;
		int               r;
		bit               quiet;

		// directed: empty table, extremes of the key, duplicates, bad positions
		push_cmd(CMD_FIND,   32'h0000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'hFFFF_FFFF, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd31, sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h0000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h8000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h0000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h7FFF_FFFF, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h8000_0001, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_FIND,   32'hFFFF_FFFF, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_FIND,   32'h0000_0000, 5'd31, sender_gap(), 1'b0);
		push_cmd(CMD_FIND,   32'h8000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_FIND,   32'h1234_5678, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31, sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'h0000_0000, 5'd31, sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'h0000_0000, 5'd5,  sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'h0000_0000, 5'd4,  sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'h0000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_DELETE, 32'h0000_0000, 5'd1,  sender_gap(), 1'b0);
		push_cmd(CMD_FIND,   32'h0000_0000, 5'd0,  sender_gap(), 1'b0);
		push_cmd(CMD_INSERT, 32'h0000_0001, 5'd0,  sender_gap(), 1'b0);

		// random: fill, churn and drain runs over a pool of keys so that
		// duplicates, hits and a full table come up often
		random_reqs = 0;
		phase = PHASE_FILL;
		while (random_reqs < RANDOM_REQS) begin
			quiet = ($urandom_range(0, 3) == 0);
			run_len = (phase == PHASE_FILL) ? $urandom_range(80, 120)
				: $urandom_range(40, 120);
			if (phase == PHASE_FILL) begin
				// new key pool: corners, near neighbors, low and high clusters
				for (int j = 0; j < POOL_SIZE; j++) begin
					r = $urandom_range(0, 9);
					case (r)
						0: begin
							case ($urandom_range(0, 3))
								0:       key_pool[j] = 32'h0000_0000;
								1:       key_pool[j] = 32'hFFFF_FFFF;
								2:       key_pool[j] = 32'h8000_0000;
								default: key_pool[j] = 32'h7FFF_FFFF;
							endcase
						end
						1, 2, 3: key_pool[j] = (j > 0) ? key_pool[j-1] + $urandom_range(1, 2)
							: $urandom;
						4, 5:    key_pool[j] = $urandom_range(0, 255);
						6:       key_pool[j] = 32'hFFFF_FF00 | $urandom_range(0, 255);
						default: key_pool[j] = $urandom;
					endcase
				end
			end
			for (int n = 0; n < run_len; n++) begin
				r = $urandom_range(0, 99);
				case (phase)
					PHASE_FILL:
						c = (r < 85) ? CMD_INSERT : (r < 95) ? CMD_FIND :
							(r < 98) ? CMD_DELETE : CMD_UNUSED;
					PHASE_CHURN:
						c = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
							(r < 95) ? CMD_FIND : CMD_UNUSED;
					default:
						c = (r < 75) ? CMD_DELETE : (r < 90) ? CMD_FIND : CMD_INSERT;
				endcase
				k = ($urandom_range(0, 4) == 0) ? $urandom
					: key_pool[$urandom_range(0, POOL_SIZE - 1)];
				if (phase == PHASE_DRAIN && $urandom_range(0, 9) < 7)
					p = POS_W'($urandom_range(0, 7));
				else
					p = POS_W'($urandom_range(0, 31));
				push_cmd(c, k, p, quiet ? 0 : sender_gap(),
					n == 0 && (random_reqs == 0 || $urandom_range(0, 2) == 0));
			end
			random_reqs += run_len;
			phase = (phase == PHASE_FILL) ? PHASE_CHURN :
				(phase == PHASE_CHURN) ? PHASE_DRAIN : PHASE_FILL;
		end

		// single reset at the start
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// let everything drain, then watch for stray results
		while (accepted_reqs < total_reqs)
			@(posedge clk);
		while (replies_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_LIMIT) @(posedge clk);

		$display("covered %0d requests: %0d insert, %0d delete, %0d find, %0d unused code",
			accepted_reqs, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_FIND],
			cmd_seen[CMD_UNUSED]);
		$display("%0d results; %0d full, %0d duplicate, %0d bad position, %0d not found",
			results_seen, full_seen, dup_seen, badpos_seen, notfound_seen);
		$display("peak fill %0d of %0d", peak_count, TABLE_DEPTH);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hang guard
	initial begin
		#25_000_000;
		$display("timeout with %0d of %0d requests taken, %0d results pending",
			accepted_reqs, total_reqs, replies_due.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
